@@ hw/rtl/wizh_pkg.sv @@
// ----------------------------------------------------------------------------
// wizh_pkg
// Shared types and constants of the window insert z-score histogram block.
// ----------------------------------------------------------------------------
package wizh_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BASE,
		ST_EVAL,
		ST_WAIT,
		ST_HIST_RD,
		ST_HIST_WR,
		ST_OUT
	} wizh_state_t;

	typedef enum logic [2:0] {
		ZS_IDLE,
		ZS_SQRT,
		ZS_MUL,
		ZS_CMP,
		ZS_DIV,
		ZS_FIN
	} zs_state_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MEAN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_STD  = 2'd3;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam logic [31:0] MIN_INSERTS = 32'd5;
	localparam logic [59:0] Z_SCALE     = 60'd2560;
	localparam int          SQRT_STEPS  = 24;
	localparam int          QUOT_W      = 12;

endpackage

@@ hw/rtl/wizh_zscore.sv @@
// ----------------------------------------------------------------------------
// wizh_zscore
// Iterative z-score bin unit: bit-pair square root, three multiplies and a
// restoring divider that yields the clamped, floored tenths-of-z bin.
// ----------------------------------------------------------------------------
module wizh_zscore #(
	parameter int HIST_BINS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [31:0]                         n,
	input  logic [47:0]                         s,
	input  logic [wizh_pkg::CFG_DATA_W-1:0]     mean,
	input  logic [wizh_pkg::CFG_DATA_W-1:0]     std,
	output logic                                done,
	output logic signed [$clog2(HIST_BINS)-1:0] bin
);
	import wizh_pkg::*;

	localparam int BW     = $clog2(HIST_BINS);
	localparam int BIN_LO = -(HIST_BINS / 2);
	localparam int BIN_HI = (HIST_BINS / 2) - 1;

	zs_state_t state_q, state_d;

	logic [55:0]       nm_q, s256_q, a_q;
	logic [47:0]       sq_v_q, sq_res_q, sq_bit_q, d_q;
	logic [4:0]        step_q;
	logic              neg_q, sat_q;
	logic [59:0]       rem_q;
	logic [QUOT_W-1:0] quo_q;

	logic [47:0]   sq_sum;
	logic          sq_ge;
	logic [59:0]   div_sub;
	logic          div_ge;
	logic [QUOT_W:0] quo_ceil;

	assign sq_sum   = sq_res_q + sq_bit_q;
	assign sq_ge    = sq_v_q >= sq_sum;
	assign div_sub  = 60'(d_q) << step_q;
	assign div_ge   = rem_q >= div_sub;
	assign quo_ceil = {1'b0, quo_q} + (QUOT_W+1)'(rem_q != 60'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ZS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			ZS_IDLE: begin
				if (start) state_d = ZS_SQRT;
			end
			ZS_SQRT: begin
				if (step_q == 5'(SQRT_STEPS - 1)) state_d = ZS_MUL;
			end
			ZS_MUL: state_d = ZS_CMP;
			ZS_CMP: begin
				if (a_q >= 56'(d_q)) state_d = ZS_FIN;
				else state_d = ZS_DIV;
			end
			ZS_DIV: begin
				if (step_q == 5'd0) state_d = ZS_FIN;
			end
			ZS_FIN: begin
				done    = 1'b1;
				state_d = ZS_IDLE;
			end
			default: state_d = ZS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ZS_IDLE: begin
				if (start) begin
					nm_q     <= 56'(n) * 56'(mean);
					s256_q   <= {s, 8'd0};
					sq_v_q   <= {n, 16'd0};
					sq_res_q <= 48'd0;
					sq_bit_q <= 48'd1 << 46;
					step_q   <= 5'd0;
				end
			end
			ZS_SQRT: begin
				if (sq_ge) begin
					sq_v_q   <= sq_v_q - sq_sum;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				step_q   <= step_q + 5'd1;
			end
			ZS_MUL: begin
				d_q   <= 48'(std) * 48'(sq_res_q[23:0]);
				neg_q <= s256_q < nm_q;
				a_q   <= (s256_q < nm_q) ? nm_q - s256_q : s256_q - nm_q;
			end
			ZS_CMP: begin
				sat_q  <= a_q >= 56'(d_q);
				rem_q  <= 60'(a_q[47:0]) * Z_SCALE;
				quo_q  <= '0;
				step_q <= 5'(QUOT_W - 1);
			end
			ZS_DIV: begin
				if (div_ge) rem_q <= rem_q - div_sub;
				quo_q  <= {quo_q[QUOT_W-2:0], div_ge};
				step_q <= step_q - 5'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (sat_q) begin
			bin = neg_q ? BW'(BIN_LO) : BW'(BIN_HI);
		end else if (!neg_q) begin
			bin = (int'(quo_q) > BIN_HI) ? BW'(BIN_HI) : BW'(quo_q);
		end else begin
			bin = (int'(quo_ceil) > HIST_BINS / 2) ? BW'(BIN_LO) : BW'(-int'(quo_ceil));
		end
	end

endmodule

@@ hw/rtl/window_insert_zscore_histogram_top.sv @@
// ----------------------------------------------------------------------------
// window_insert_zscore_histogram_top
// Sliding-window insert count and length sums over a prefix-sum ring, with
// a z-score bin histogram of windows holding more than five inserts.
// ----------------------------------------------------------------------------
// a sample that closes no window is taken with no stall; a histogram read
// passes the read and output states; a window of five inserts or fewer the
// base (not for the first window), evaluation and output states; a binned
// window adds the 24-step square root and 12-step divider of the z-score unit
// (no divider at a saturated bin) and the update; after reset the histogram
// is cleared one bin a cycle, samples stalled; cfg writes are taken throughout
module window_insert_zscore_histogram_top #(
	parameter int WINDOW_MAX = 4096,
	parameter int HIST_BINS  = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic                            operation,
	input  logic [15:0]                     starting_inserts,
	input  logic [31:0]                     length_sum,
	input  logic                            last_position,
	input  logic signed [9:0]               bin_select,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            result_kind,
	output logic                            window_counted,
	output logic signed [9:0]               z_bin,
	output logic [31:0]                     window_inserts,
	output logic [31:0]                     bin_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wizh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wizh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wizh_pkg::*;

	localparam int AW    = $clog2(WINDOW_MAX);
	localparam int WSZ_W = $clog2(WINDOW_MAX + 1);
	localparam int BW    = $clog2(HIST_BINS);

	// configuration
	logic [12:0]           size_q, wstep_q;
	logic [CFG_DATA_W-1:0] mean_q, std_q;

	// per-sequence state
	logic [31:0]   run_cnt_q, pos_q, next_end_q;
	logic [47:0]   run_len_q;
	logic          first_done_q;
	logic [AW-1:0] ptr_q;

	wizh_state_t state_q, state_d;
	logic [BW-1:0] clr_q;

	// memories
	logic [79:0] ring_mem [WINDOW_MAX];
	logic [79:0] ring_rd_q;
	logic [31:0] hist_mem [HIST_BINS];
	logic [31:0] hist_rd_q;

	// work registers
	logic                 kind_q, base_ok_q, sel_ok_q, counted_q;
	logic signed [9:0]    sel_q;
	logic [BW-1:0]        hidx_q;
	logic [31:0]          old_cnt_q, n_q, cnt_q;
	logic [47:0]          old_len_q, s_q;
	logic signed [BW-1:0] bin_q;

	// output word
	logic                 result_valid_q, kind_o_q, counted_o_q;
	logic signed [9:0]    zbin_o_q;
	logic [31:0]          inserts_o_q, count_o_q;

	logic [WSZ_W-1:0] wsz_c;
	logic [12:0]      wstep_c;
	logic [AW-1:0]    ri_c;
	int               ri_sum;
	logic             accept, accept_sample, late_c, first_c, has_base_c;
	logic [31:0]      new_cnt;
	logic [47:0]      new_len, len_c;
	int               sel_idx;
	logic             hist_we, zs_start, zs_done, out_load;
	logic [BW-1:0]    hist_waddr;
	logic [31:0]      hist_wdata, hist_inc;
	logic signed [BW-1:0] zs_bin;
	logic signed [31:0]   bin_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= 13'd1000;
			wstep_q <= 13'd100;
			mean_q  <= '0;
			std_q   <= CFG_DATA_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW_SIZE:   size_q  <= cfg_data[12:0];
				CFG_WINDOW_STEP:   wstep_q <= cfg_data[12:0];
				CFG_EXPECTED_MEAN: mean_q  <= cfg_data;
				CFG_EXPECTED_STD:  std_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_q == 13'd0) wsz_c = WSZ_W'(1);
		else if (32'(size_q) > WINDOW_MAX) wsz_c = WSZ_W'(WINDOW_MAX);
		else wsz_c = WSZ_W'(size_q);
	end

	assign wstep_c = (wstep_q == 13'd0) ? 13'd1 : wstep_q;
	assign ri_sum  = int'(ptr_q) + WINDOW_MAX - int'(wsz_c);
	assign ri_c    = AW'((ri_sum >= WINDOW_MAX) ? ri_sum - WINDOW_MAX : ri_sum);

	assign accept        = sample_valid && !sample_stall;
	assign accept_sample = accept && (operation == OP_SAMPLE);
	assign late_c        = first_done_q && (pos_q == next_end_q);
	assign has_base_c    = 32'(wsz_c) <= pos_q;
	assign first_c       = !first_done_q &&
	                       ((33'(pos_q) + 33'd1 >= 33'(wsz_c)) || last_position);
	assign len_c         = (starting_inserts != 16'd0) ? 48'(length_sum) : 48'd0;
	assign new_cnt       = run_cnt_q + 32'(starting_inserts);
	assign new_len       = run_len_q + len_c;
	assign sel_idx       = int'(bin_select) + HIST_BINS / 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q    <= '0;
			run_len_q    <= '0;
			pos_q        <= '0;
			next_end_q   <= '0;
			first_done_q <= 1'b0;
			ptr_q        <= '0;
		end else if (accept_sample) begin
			if (last_position) begin
				run_cnt_q    <= '0;
				run_len_q    <= '0;
				pos_q        <= '0;
				next_end_q   <= '0;
				first_done_q <= 1'b0;
				ptr_q        <= '0;
			end else begin
				run_cnt_q <= new_cnt;
				run_len_q <= new_len;
				pos_q     <= pos_q + 32'd1;
				ptr_q     <= (ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : ptr_q + AW'(1);
				if (late_c) next_end_q <= next_end_q + 32'(wstep_c);
				if (first_c) begin
					first_done_q <= 1'b1;
					next_end_q   <= pos_q + 32'd1 + 32'(wstep_c);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + BW'(1);
		end
	end

	always_comb begin
		state_d  = state_q;
		hist_we  = 1'b0;
		zs_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
				if (clr_q == BW'(HIST_BINS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_READ) state_d = ST_HIST_RD;
					else if (late_c) state_d = ST_BASE;
					else if (first_c) state_d = ST_EVAL;
				end
			end
			ST_BASE: state_d = ST_EVAL;
			ST_EVAL: begin
				if (n_q > MIN_INSERTS) begin
					zs_start = 1'b1;
					state_d  = ST_WAIT;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_WAIT: begin
				if (zs_done) state_d = ST_HIST_RD;
			end
			ST_HIST_RD: state_d = (kind_q == KIND_READ) ? ST_OUT : ST_HIST_WR;
			ST_HIST_WR: begin
				hist_we = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= operation;
			sel_q     <= bin_select;
			sel_ok_q  <= (sel_idx >= 0) && (sel_idx < HIST_BINS);
			old_cnt_q <= run_cnt_q;
			old_len_q <= run_len_q;
			base_ok_q <= has_base_c;
			n_q       <= new_cnt;
			s_q       <= new_len;
			if (operation == OP_READ) hidx_q <= BW'(sel_idx);
		end
		if (state_q == ST_BASE) begin
			n_q <= old_cnt_q - (base_ok_q ? ring_rd_q[79:48] : 32'd0);
			s_q <= old_len_q - (base_ok_q ? ring_rd_q[47:0] : 48'd0);
		end
		if (state_q == ST_EVAL) counted_q <= n_q > MIN_INSERTS;
		if (state_q == ST_WAIT && zs_done) begin
			bin_q  <= zs_bin;
			hidx_q <= BW'(int'(zs_bin) + HIST_BINS / 2);
		end
		if (state_q == ST_HIST_WR) cnt_q <= hist_inc;
	end

	// prefix ring: read the window base while the current prefix is stored
	always_ff @(posedge clk) begin
		if (accept_sample) begin
			ring_mem[ptr_q] <= {run_cnt_q, run_len_q};
			ring_rd_q       <= ring_mem[ri_c];
		end
	end

	assign hist_inc   = (hist_rd_q == 32'hFFFF_FFFF) ? hist_rd_q : hist_rd_q + 32'd1;
	assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : hidx_q;
	assign hist_wdata = (state_q == ST_CLEAR) ? 32'd0 : hist_inc;

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		if (state_q == ST_HIST_RD) hist_rd_q <= hist_mem[hidx_q];
	end

	wizh_zscore #(
		.HIST_BINS(HIST_BINS)
	) u_zscore (
		.clk   (clk),
		.arst_n(arst_n),
		.start (zs_start),
		.n     (n_q),
		.s     (s_q),
		.mean  (mean_q),
		.std   ((std_q == '0) ? CFG_DATA_W'(1) : std_q),
		.done  (zs_done),
		.bin   (zs_bin)
	);

	assign bin_ext = 32'(bin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_o_q    <= kind_q;
			counted_o_q <= (kind_q == KIND_WINDOW) && counted_q;
			if (kind_q == KIND_READ) begin
				zbin_o_q    <= sel_q;
				inserts_o_q <= 32'd0;
				count_o_q   <= sel_ok_q ? hist_rd_q : 32'd0;
			end else begin
				zbin_o_q    <= counted_q ? bin_ext[9:0] : 10'sd0;
				inserts_o_q <= n_q;
				count_o_q   <= counted_q ? cnt_q : 32'd0;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign result_kind    = kind_o_q;
	assign window_counted = counted_o_q;
	assign z_bin          = zbin_o_q;
	assign window_inserts = inserts_o_q;
	assign bin_count      = count_o_q;

`ifndef ASSERT_OFF
	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_OUT))
		else $error("result word without a finished item");
	a_no_sample_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> sample_stall)
		else $error("sample taken during histogram clear");
	a_zs_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		zs_done |-> (state_q == ST_WAIT))
		else $error("z-score result outside wait");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= AW'(WINDOW_MAX - 1))
		else $error("ring pointer out of range");
	a_hist_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HIST_WR) |-> $past(state_q == ST_HIST_RD))
		else $error("histogram write without fresh read");
`endif

endmodule
